FILE: design/adc_data_frame_receiver_assert.svh
`ifndef ADC_DATA_FRAME_RECEIVER_ASSERT_SVH
`define ADC_DATA_FRAME_RECEIVER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define ADRX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define ADRX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/adrx_pkg.sv
`default_nettype none

package adrx_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [31:0] ERR_READING = 32'hFFFF_FFFF;
    localparam int          ADDR_W      = 3;

    // Register indexes (paddr[2])
    localparam logic REG_STATUS_EN = 1'b0;
    localparam logic REG_CRC_EN    = 1'b1;

    typedef struct packed {
        logic status_enabled;
        logic crc_enabled;
    } cfg_t;

    typedef struct packed {
        logic [31:0] reading;
        logic        crc_good;
        logic [7:0]  status_byte;
        logic        status_fresh;
    } result_t;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/adrx_frame.sv
`default_nettype none

module adrx_frame (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire adrx_pkg::cfg_t   cfg,
    input  wire logic             take,
    input  wire logic [7:0]       data_byte,
    input  wire logic             frame_start,
    output logic                  res_valid,
    output adrx_pkg::result_t     res
);

    logic [2:0]  pos_reg,     pos_next;
    logic [7:0]  crc_reg,     crc_next;
    logic [23:0] shift_reg,   shift_next;
    logic [7:0]  pending_reg, pending_next;
    logic [7:0]  kept_reg,    kept_next;

    logic [2:0]  pos;
    logic [7:0]  crc;
    logic [23:0] shift;
    logic [2:0]  last_sample;
    logic [7:0]  crc_fed;
    logic        good;
    logic        fresh;

    // Decode the byte's role and advance the frame state
    always_comb
    begin
        pos         = frame_start ? 3'd0 : pos_reg;
        crc         = frame_start ? 8'd0 : crc_reg;
        shift       = frame_start ? 24'd0 : shift_reg;
        last_sample = {2'b00, cfg.status_enabled} + 3'd2;
        crc_fed     = adrx_pkg::crc8_feed(crc, data_byte);

        pos_next     = pos;
        crc_next     = crc;
        shift_next   = shift;
        pending_next = pending_reg;
        res_valid    = 1'b0;
        good         = 1'b1;

        if (cfg.status_enabled && pos == 3'd0)
        begin
            pending_next = data_byte;
            crc_next     = crc_fed;
            pos_next     = pos + 3'd1;
        end
        else if (pos <= last_sample)
        begin
            shift_next = {shift[15:0], data_byte};
            crc_next   = crc_fed;
            if (pos == last_sample && !cfg.crc_enabled)
            begin
                res_valid = 1'b1;
                pos_next  = 3'd0;
            end
            else
            begin
                pos_next = pos + 3'd1;
            end
        end
        else if (cfg.crc_enabled && pos == last_sample + 3'd1)
        begin
            good      = (data_byte == crc);
            res_valid = 1'b1;
            pos_next  = 3'd0;
        end
        else
        begin
            // drop a byte past the end of the frame
            pos_next = 3'd0;
        end

        fresh     = res_valid && good && cfg.status_enabled;
        kept_next = fresh ? pending_reg : kept_reg;

        res.reading      = good ? {8'h00, shift_next} : adrx_pkg::ERR_READING;
        res.crc_good     = good;
        res.status_byte  = kept_next;
        res.status_fresh = fresh;

        // restart the accumulators once a frame completes
        if (res_valid)
        begin
            crc_next   = 8'd0;
            shift_next = 24'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 3'd0;
            crc_reg     <= 8'd0;
            shift_reg   <= 24'd0;
            pending_reg <= 8'd0;
            kept_reg    <= 8'd0;
        end
        else if (take)
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            shift_reg   <= shift_next;
            pending_reg <= pending_next;
            kept_reg    <= kept_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/adc_data_frame_receiver.sv
// A frame's result is registered into the output register, or into the skid register when
// the output register is stalled. Throughput: one byte per cycle while the skid is empty;
// the frame logic is a single pass between registers. A two-deep output stage (register
// plus skid) lets bytes flow while a result is stalled. Reset (rst_n, asynchronous, active
// low) clears the frame state, kept status, registers and both output stages.
`default_nettype none

module adc_data_frame_receiver (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // APB configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [adrx_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // byte stream in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  wire logic                        s_axis_tuser,   // [0] frame_start
    // result stream out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [39:0]                 m_axis_tdata,   // [31:0] reading, [39:32] status_byte
    output logic      [1:0]                  m_axis_tuser    // [0] crc_good, [1] status_fresh
);

    adrx_pkg::cfg_t    cfg_reg;
    adrx_pkg::result_t res;
    adrx_pkg::result_t out_reg;
    adrx_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              take;
    logic              res_valid;
    logic              pop;
    logic              cfg_wr;

    // Register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                adrx_pkg::REG_STATUS_EN: cfg_reg.status_enabled <= pwdata[0];
                adrx_pkg::REG_CRC_EN:    cfg_reg.crc_enabled    <= pwdata[0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (paddr[2])
            adrx_pkg::REG_STATUS_EN: prdata = {31'd0, cfg_reg.status_enabled};
            adrx_pkg::REG_CRC_EN:    prdata = {31'd0, cfg_reg.crc_enabled};
            default:                 prdata = 32'd0;
        endcase
    end

    // Frame decode and CRC check
    assign s_axis_tready = !skid_valid_reg;
    assign take          = s_axis_tvalid && s_axis_tready;

    adrx_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .take        (take),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register with skid stage
    assign pop = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (take && res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (take && res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.status_byte, out_reg.reading};
    assign m_axis_tuser  = {out_reg.status_fresh, out_reg.crc_good};

endmodule

`default_nettype wire

FILE: design/adrx_checker.sv
`default_nettype none

`include "adc_data_frame_receiver_assert.svh"

module adrx_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [39:0]                 m_axis_tdata,
    input wire logic [1:0]                  m_axis_tuser
);

    // A stalled result beat stays offered
    `ADRX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")

    // A failed check carries the error reading
    `ADRX_ASSERT_NOW(a_bad_reading, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:0] == 32'hFFFF_FFFF, "failed frame without error reading")

    // A good reading is a zero-extended 24-bit sample
    `ADRX_ASSERT_NOW(a_good_width, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:24] == 8'h00, "good reading wider than 24 bits")

    // Status is refreshed only by a good frame
    `ADRX_ASSERT_NOW(a_fresh_good, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "status refreshed on a failed frame")

endmodule

bind adc_data_frame_receiver adrx_checker u_adrx_checker (.*);

`default_nettype wire
